// ===== rtl/core/mmts_pkg.sv =====
// Shared types and codes for the march memory test sequencer.
// Used by mmts_step and march_memory_test_sequencer_core; depends on nothing.
`default_nettype none

package mmts_pkg;

    // Fixed widths of the sequencing state and of the configuration port.
    localparam int WORD_INDEX_BITS = 21;
    localparam int ERROR_BITS      = 32;

    // Request codes carried by the input word.
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BASE_ADDRESS = 1'b0;
    localparam logic CFG_WORD_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_IDLE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_DONE  = 2'd3
    } cmd_op_t;

    // March elements in test order; ELEM_END marks a finished test.
    typedef enum logic [2:0] {
        ELEM_UP_W   = 3'd0,
        ELEM_UP_RW0 = 3'd1,
        ELEM_UP_RW1 = 3'd2,
        ELEM_DN_RW0 = 3'd3,
        ELEM_DN_RW1 = 3'd4,
        ELEM_UP_R   = 3'd5,
        ELEM_END    = 3'd6
    } elem_t;

    // Pattern pairs (p0, p1).
    typedef enum logic [1:0] {
        PAIR_ZERO_W1 = 2'd0,
        PAIR_W0_ZERO = 2'd1,
        PAIR_W0_W1   = 2'd2
    } pair_t;

    // Sequencing state that does not depend on the data or address width.
    typedef struct packed {
        logic                         running;
        pair_t                        pattern_pair;
        elem_t                        march_element;
        logic [WORD_INDEX_BITS-1:0]   word_index;
        logic                         write_phase;
        logic                         pending_read;
        logic [ERROR_BITS-1:0]        mismatches;
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mmts_step.sv =====
// One sequencer step: checks the returned read data, forms the next command
// and advances the march position. Depends on mmts_pkg.
`default_nettype none

module mmts_step #(
    parameter int ADDR_BITS = 20,
    parameter int DATA_BITS = 32
) (
    input  wire logic                                   start,
    input  wire logic [DATA_BITS-1:0]                   read_data,
    input  wire logic [ADDR_BITS-1:0]                   base_address,
    input  wire logic [mmts_pkg::WORD_INDEX_BITS-1:0]   word_count,
    input  wire mmts_pkg::seq_state_t                   cur_state,
    input  wire logic [$clog2(DATA_BITS)-1:0]           cur_bit,
    input  wire logic [DATA_BITS-1:0]                   cur_expect,
    output mmts_pkg::seq_state_t                        nxt_state,
    output logic [$clog2(DATA_BITS)-1:0]                nxt_bit,
    output logic [DATA_BITS-1:0]                        nxt_expect,
    output mmts_pkg::cmd_op_t                           cmd_op,
    output logic [ADDR_BITS-1:0]                        cmd_addr,
    output logic [DATA_BITS-1:0]                        cmd_data,
    output logic [mmts_pkg::ERROR_BITS-1:0]             error_count
);

    localparam int BIT_W = $clog2(DATA_BITS);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DATA_BITS - 1);
    localparam logic [mmts_pkg::ERROR_BITS-1:0] ERROR_ONE = mmts_pkg::ERROR_BITS'(1);

    mmts_pkg::seq_state_t                   eff;
    logic [BIT_W-1:0]                       eff_bit;
    logic [DATA_BITS-1:0]                   eff_expect;
    logic                                   active;
    logic [DATA_BITS-1:0]                   w1;
    logic [DATA_BITS-1:0]                   w0;
    logic [DATA_BITS-1:0]                   p0;
    logic [DATA_BITS-1:0]                   p1;
    logic                                   down;
    logic                                   single;
    logic [ADDR_BITS-1:0]                   idx;
    logic [mmts_pkg::WORD_INDEX_BITS-1:0]   idx_inc;
    logic [2:0]                             elem_inc;

    // A start clears the sequence; otherwise the previous read is checked.
    always_comb begin
        eff        = cur_state;
        eff_bit    = cur_bit;
        eff_expect = cur_expect;
        if (start) begin
            eff.running       = 1'b1;
            eff.pattern_pair  = mmts_pkg::PAIR_ZERO_W1;
            eff.march_element = (word_count == '0) ? mmts_pkg::ELEM_END
                                                   : mmts_pkg::ELEM_UP_W;
            eff.word_index    = '0;
            eff.write_phase   = 1'b0;
            eff.pending_read  = 1'b0;
            eff.mismatches    = '0;
            eff_bit           = '0;
            eff_expect        = '0;
        end else if (cur_state.pending_read) begin
            if ((read_data != cur_expect) && (cur_state.mismatches != '1)) begin
                eff.mismatches = cur_state.mismatches + ERROR_ONE;
            end
            eff.pending_read = 1'b0;
        end
    end

    assign active = eff.running && (eff.march_element < mmts_pkg::ELEM_END);
    assign w1     = DATA_BITS'(1) << eff_bit;
    assign w0     = ~w1;
    assign p0     = (eff.pattern_pair == mmts_pkg::PAIR_ZERO_W1) ? '0 : w0;
    assign p1     = (eff.pattern_pair == mmts_pkg::PAIR_W0_ZERO) ? '0 : w1;
    assign down   = (eff.march_element == mmts_pkg::ELEM_DN_RW0) ||
                    (eff.march_element == mmts_pkg::ELEM_DN_RW1);
    assign single = (eff.march_element == mmts_pkg::ELEM_UP_W) ||
                    (eff.march_element == mmts_pkg::ELEM_UP_R);
    assign idx    = down ? (ADDR_BITS'(word_count) - ADDR_BITS'(eff.word_index)
                            - ADDR_BITS'(1))
                         : ADDR_BITS'(eff.word_index);
    assign idx_inc  = eff.word_index + mmts_pkg::WORD_INDEX_BITS'(1);
    assign elem_inc = 3'(eff.march_element) + 3'd1;

    // Command for the current position.
    always_comb begin
        cmd_op   = mmts_pkg::CMD_IDLE;
        cmd_addr = '0;
        cmd_data = '0;
        if (!active) begin
            cmd_op = (eff.running || eff.march_element >= mmts_pkg::ELEM_END)
                     ? mmts_pkg::CMD_DONE : mmts_pkg::CMD_IDLE;
        end else begin
            cmd_addr = base_address + idx;
            unique case (eff.march_element)
                mmts_pkg::ELEM_UP_W: begin
                    cmd_op   = mmts_pkg::CMD_WRITE;
                    cmd_data = p0;
                end
                mmts_pkg::ELEM_UP_R: begin
                    cmd_op   = mmts_pkg::CMD_READ;
                    cmd_data = p0;
                end
                mmts_pkg::ELEM_UP_RW0, mmts_pkg::ELEM_DN_RW0: begin
                    cmd_op   = eff.write_phase ? mmts_pkg::CMD_WRITE : mmts_pkg::CMD_READ;
                    cmd_data = eff.write_phase ? p1 : p0;
                end
                mmts_pkg::ELEM_UP_RW1, mmts_pkg::ELEM_DN_RW1: begin
                    cmd_op   = eff.write_phase ? mmts_pkg::CMD_WRITE : mmts_pkg::CMD_READ;
                    cmd_data = eff.write_phase ? p0 : p1;
                end
                default: begin
                    cmd_op = mmts_pkg::CMD_IDLE;
                end
            endcase
        end
    end

    // March position update.
    always_comb begin
        nxt_state  = eff;
        nxt_bit    = eff_bit;
        nxt_expect = eff_expect;
        if (!active) begin
            nxt_state.running      = 1'b0;
            nxt_state.pending_read = 1'b0;
            if (eff.running) begin
                nxt_state.march_element = mmts_pkg::ELEM_END;
            end
        end else begin
            nxt_state.pending_read = (cmd_op == mmts_pkg::CMD_READ);
            if (cmd_op == mmts_pkg::CMD_READ) begin
                nxt_expect = cmd_data;
            end
            if (!single && !eff.write_phase) begin
                nxt_state.write_phase = 1'b1;
            end else begin
                nxt_state.write_phase = 1'b0;
                if (idx_inc < word_count) begin
                    nxt_state.word_index = idx_inc;
                end else begin
                    nxt_state.word_index = '0;
                    if (elem_inc < 3'(mmts_pkg::ELEM_END)) begin
                        nxt_state.march_element = mmts_pkg::elem_t'(elem_inc);
                    end else begin
                        nxt_state.march_element = mmts_pkg::ELEM_UP_W;
                        if (eff.pattern_pair != mmts_pkg::PAIR_W0_W1) begin
                            nxt_state.pattern_pair =
                                mmts_pkg::pair_t'(2'(eff.pattern_pair) + 2'd1);
                        end else begin
                            nxt_state.pattern_pair = mmts_pkg::PAIR_ZERO_W1;
                            if (eff_bit != LAST_BIT) begin
                                nxt_bit = eff_bit + BIT_W'(1);
                            end else begin
                                nxt_state.march_element = mmts_pkg::ELEM_END;
                            end
                        end
                    end
                end
            end
        end
    end

    assign error_count = eff.mismatches;

endmodule

`default_nettype wire

// ===== rtl/core/march_memory_test_sequencer_core.sv =====
// Top level of the march memory test sequencer: input register, sequencing
// state, configuration registers and result register. Depends on mmts_pkg, mmts_step.
`default_nettype none

// March memory self-test sequencer. For every bit position and each of the
// three pattern pairs (0, walking one), (walking zero, 0) and (walking zero,
// walking one) it walks the six march elements over word_count words from
// base_address. Send a word with req_type 0 to start or restart the test;
// every later word with req_type 1 carries the data returned for the previous
// command and is answered by the next command (write, read with the expected
// value, or done). Exactly one result word comes back for each input word.
// The block takes one word per cycle and gives one result per cycle while
// m_ready is high; an accepted word waits in the input register until the
// result register is free or being emptied, and its result then loads there.
// The step itself, one pass of compare, index update and address add, is
// combinational between the input register and the result register. An input
// register and the result register separate the two channels, so a new word
// is taken while a result still waits. Mismatches saturate at all ones.
// Configuration writes take effect at once and belong to idle periods.
module march_memory_test_sequencer_core #(
    parameter int ADDR_BITS = 20,
    parameter int DATA_BITS = 32,
    // The configuration data port is as wide as the wider register.
    localparam int CFG_BITS = (ADDR_BITS > mmts_pkg::WORD_INDEX_BITS)
                              ? ADDR_BITS : mmts_pkg::WORD_INDEX_BITS
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_wr_en,
    input  wire logic                                        cfg_index,
    input  wire logic [CFG_BITS-1:0]                         cfg_data,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  wire logic                                        s_req_type,
    input  wire logic [DATA_BITS-1:0]                        s_read_data,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output logic [1:0]                                       m_cmd_op,
    output logic [ADDR_BITS-1:0]                             m_cmd_addr,
    output logic [DATA_BITS-1:0]                             m_cmd_data,
    output logic [mmts_pkg::ERROR_BITS-1:0]                  m_error_count
);

    localparam int BIT_W = $clog2(DATA_BITS);
    localparam logic [mmts_pkg::WORD_INDEX_BITS-1:0] WORD_COUNT_RESET =
        mmts_pkg::WORD_INDEX_BITS'(1024);

    // Configuration registers.
    logic [ADDR_BITS-1:0]                   base_reg;
    logic [mmts_pkg::WORD_INDEX_BITS-1:0]   count_reg;

    // Input stage.
    logic                                   in_valid_reg;
    logic                                   in_req_reg;
    logic [DATA_BITS-1:0]                   in_data_reg;

    // Sequencing state.
    mmts_pkg::seq_state_t                   seq_reg;
    mmts_pkg::seq_state_t                   seq_next;
    logic [BIT_W-1:0]                       bit_reg;
    logic [BIT_W-1:0]                       bit_next;
    logic [DATA_BITS-1:0]                   expect_reg;
    logic [DATA_BITS-1:0]                   expect_next;

    // Result stage.
    logic                                   out_valid_reg;
    mmts_pkg::cmd_op_t                      out_op_reg;
    mmts_pkg::cmd_op_t                      op_next;
    logic [ADDR_BITS-1:0]                   out_addr_reg;
    logic [ADDR_BITS-1:0]                   addr_next;
    logic [DATA_BITS-1:0]                   out_data_reg;
    logic [DATA_BITS-1:0]                   data_next;
    logic [mmts_pkg::ERROR_BITS-1:0]        out_err_reg;
    logic [mmts_pkg::ERROR_BITS-1:0]        err_next;

    logic                                   advance;

    // A step runs whenever a word waits in the input stage and the result
    // register is free or being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            count_reg <= WORD_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mmts_pkg::CFG_BASE_ADDRESS: base_reg  <= cfg_data[ADDR_BITS-1:0];
                mmts_pkg::CFG_WORD_COUNT:
                    count_reg <= cfg_data[mmts_pkg::WORD_INDEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= s_req_type;
            in_data_reg <= s_read_data;
        end
    end

    mmts_step #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_step (
        .start        (in_req_reg == mmts_pkg::REQ_START),
        .read_data    (in_data_reg),
        .base_address (base_reg),
        .word_count   (count_reg),
        .cur_state    (seq_reg),
        .cur_bit      (bit_reg),
        .cur_expect   (expect_reg),
        .nxt_state    (seq_next),
        .nxt_bit      (bit_next),
        .nxt_expect   (expect_next),
        .cmd_op       (op_next),
        .cmd_addr     (addr_next),
        .cmd_data     (data_next),
        .error_count  (err_next)
    );

    // The sequencing state and the result register load together, so the
    // state always describes the command last placed in the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= '0;
            bit_reg    <= '0;
            expect_reg <= '0;
        end else if (advance) begin
            seq_reg    <= seq_next;
            bit_reg    <= bit_next;
            expect_reg <= expect_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_op_reg   <= op_next;
            out_addr_reg <= addr_next;
            out_data_reg <= data_next;
            out_err_reg  <= err_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cmd_op      = out_op_reg;
    assign m_cmd_addr    = out_addr_reg;
    assign m_cmd_data    = out_data_reg;
    assign m_error_count = out_err_reg;

    // A pending read always matches the read command waiting at the output.
    a_read_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_op_reg == mmts_pkg::CMD_READ)
        |-> (seq_reg.pending_read && expect_reg == out_data_reg))
        else $error("read command without matching pending expectation");

    // The reported error count is the live mismatch count.
    a_err_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_err_reg == seq_reg.mismatches))
        else $error("error count out of step with mismatch counter");

    // No read can be outstanding once the test has stopped.
    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !seq_reg.running |-> !seq_reg.pending_read)
        else $error("pending read while sequencer is stopped");

    // Every step leaves a result in the output register.
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("step taken without producing a result");

endmodule

`default_nettype wire
